### sv/fupa_pkg.sv
`default_nettype none

package fupa_pkg;

	localparam int MAX_POCKETS_DEF = 16;
	localparam int MAX_GAPS_DEF    = 256;
	localparam int ADDR_W          = 32;
	localparam int UNIT_W          = 17;
	localparam int POCKET_W        = 21;
	localparam int POCKET_IDX_W    = 4;
	localparam int BUMP_W          = 21;

	localparam logic [UNIT_W-1:0]   UNIT_BYTES_RST   = 17'd8;
	localparam logic [POCKET_W-1:0] POCKET_BYTES_RST = 21'd2048;
	localparam logic [ADDR_W-1:0]   POOL_BASE_RST    = 32'd0;
	localparam logic [POCKET_W-1:0] FREE_MAX         = 21'h1FFFFF;

	typedef enum logic [1:0] {
		CFG_UNIT_BYTES   = 2'd0,
		CFG_POCKET_BYTES = 2'd1,
		CFG_POOL_BASE    = 2'd2,
		CFG_UNUSED       = 2'd3
	} cfg_idx_t;

	typedef enum logic [1:0] {
		STAT_OK        = 2'd0,
		STAT_NO_POCKET = 2'd1,
		STAT_OUTSIDE   = 2'd2,
		STAT_GAP_FULL  = 2'd3
	} status_t;

	typedef enum logic [0:0] {
		OP_ALLOC = 1'b0,
		OP_FREE  = 1'b1
	} op_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_ACHK,
		S_ASCAN,
		S_AREAD,
		S_ABUMP,
		S_AMUL,
		S_AADD,
		S_FMUL,
		S_FSTART,
		S_FSCAN,
		S_EMIT
	} state_t;

endpackage

`default_nettype wire

### sv/fixed_unit_pool_allocator.sv
// Fixed-size unit pool allocator.
// Input channel (in_valid / in_stall): one item carries an operation (allocate or
// free) and, for a free, the byte address being released. An item is taken on a
// rising edge with in_valid high and in_stall low. Output channel (out_valid /
// out_stall): one item per input item with unit_address, pocket_used and status.
// Configuration (cfg_valid / cfg_ready, always ready): index 0 unit_bytes,
// 1 pocket_bytes, 2 pool_base; index 3 is ignored. Write only while idle.
// From the accepting edge to the edge that raises out_valid, an allocate passes a
// check state, scan states from pocket zero up to the current pocket, then a gap
// read for a gap reuse or the bump, multiply and add states for a bump, and the
// final state, which loads the output register; with no pocket left the check leads
// straight to the final state. A free passes a multiply state, a start state, scan
// states from the current pocket down and the final state. The next item is taken
// in the idle state that follows. A small sequencer walks the per-pocket state one
// pocket a cycle and shares a single 21x21 multiplier for pocket start and bump
// offsets; the gap store is a one-write, one-read RAM with registered read. One
// item is in flight at a time; in_stall is high while it is worked on. A finished
// item waits in the final state while out_stall holds the output register.
// Reset (arst_n low) restores config and control registers, opens pocket zero
// with pocket_bytes free and empties all gap queues at once; no sweep is needed.
`default_nettype none

module fixed_unit_pool_allocator #(
	parameter int MAX_POCKETS         = fupa_pkg::MAX_POCKETS_DEF,
	parameter int MAX_GAPS_PER_POCKET = fupa_pkg::MAX_GAPS_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	// configuration write channel
	input  wire logic                           cfg_valid,
	output logic                                cfg_ready,
	input  wire logic [1:0]                     cfg_index,
	input  wire logic [fupa_pkg::ADDR_W-1:0]    cfg_data,
	// input item channel
	input  wire logic                           in_valid,
	output logic                                in_stall,
	input  wire logic                           operation,
	input  wire logic [fupa_pkg::ADDR_W-1:0]    free_address,
	// result item channel
	output logic                                out_valid,
	input  wire logic                           out_stall,
	output logic      [fupa_pkg::ADDR_W-1:0]    unit_address,
	output logic      [fupa_pkg::POCKET_IDX_W-1:0] pocket_used,
	output logic      [1:0]                     status
);

	localparam int AW   = fupa_pkg::ADDR_W;
	localparam int UW   = fupa_pkg::UNIT_W;
	localparam int PBW  = fupa_pkg::POCKET_W;
	localparam int BW   = fupa_pkg::BUMP_W;
	localparam int PW   = (MAX_POCKETS > 1) ? $clog2(MAX_POCKETS) : 1;
	localparam int GW   = (MAX_GAPS_PER_POCKET > 1) ? $clog2(MAX_GAPS_PER_POCKET) : 1;
	localparam int CW   = $clog2(MAX_GAPS_PER_POCKET + 1);
	localparam int RD   = MAX_POCKETS * MAX_GAPS_PER_POCKET;
	localparam int RAW  = (RD > 1) ? $clog2(RD) : 1;
	localparam int MW   = 2 * PBW;

	// Configuration registers.
	logic [UW-1:0]  unit_bytes_q;
	logic [PBW-1:0] pocket_bytes_q;
	logic [AW-1:0]  pool_base_q;

	// Allocator state. Pocket cur_q is the newest open pocket.
	logic [PW-1:0]  cur_q;
	logic [BW-1:0]  bump_q;
	logic [PBW-1:0] free_q  [MAX_POCKETS];
	logic [CW-1:0]  gcnt_q  [MAX_POCKETS];
	logic [GW-1:0]  ghead_q [MAX_POCKETS];
	logic [GW-1:0]  gtail_q [MAX_POCKETS];

	// Sequencer and datapath registers.
	fupa_pkg::state_t state_q, state_d;
	logic           op_q;
	logic [AW-1:0]  addr_q;
	logic [PW-1:0]  idx_q;
	logic [AW-1:0]  prod_q;
	logic [AW-1:0]  acc_q;
	logic [AW-1:0]  res_addr_q;
	logic [PW-1:0]  res_pocket_q;
	fupa_pkg::status_t res_stat_q;

	logic [AW-1:0]  out_addr_q;
	logic [fupa_pkg::POCKET_IDX_W-1:0] out_pocket_q;
	fupa_pkg::status_t out_stat_q;
	logic           out_valid_q;

	// Values of the pocket under the scan index.
	logic [PBW-1:0] fb;
	logic [CW-1:0]  gc;
	logic [GW-1:0]  gh, gt;
	logic           fb_short;
	logic           cur_last;
	logic           idx_is_cur;
	logic           idx_zero;
	logic           in_range;
	logic           gap_full;
	logic [AW-1:0]  offset;
	logic [PBW:0]   credit_sum;
	logic [PBW-1:0] credit_val;
	logic [PBW-1:0] debit_val;
	logic           accept;
	logic           can_emit;

	// Shared multiplier.
	logic [PBW-1:0] mul_a, mul_b;
	logic [MW-1:0]  mul_p;

	// Gap store.
	logic           ram_we, ram_re;
	logic [RAW-1:0] ram_base, ram_waddr, ram_raddr;
	logic [AW-1:0]  ram_rdata;

	assign fb         = free_q[idx_q];
	assign gc         = gcnt_q[idx_q];
	assign gh         = ghead_q[idx_q];
	assign gt         = gtail_q[idx_q];
	assign fb_short   = {1'b0, fb} < {{(PBW + 1 - UW){1'b0}}, unit_bytes_q};
	assign cur_last   = (cur_q == PW'(MAX_POCKETS - 1));
	assign idx_is_cur = (idx_q == cur_q);
	assign idx_zero   = (idx_q == '0);
	assign offset     = addr_q - acc_q;
	assign in_range   = offset < {{(AW - PBW){1'b0}}, pocket_bytes_q};
	assign gap_full   = (gc >= CW'(MAX_GAPS_PER_POCKET));
	assign credit_sum = {1'b0, fb} + {{(PBW + 1 - UW){1'b0}}, unit_bytes_q};
	assign credit_val = credit_sum[PBW] ? fupa_pkg::FREE_MAX : credit_sum[PBW-1:0];
	assign debit_val  = fb_short ? '0 : (fb - {{(PBW - UW){1'b0}}, unit_bytes_q});
	assign accept     = in_valid && !in_stall;
	assign can_emit   = !out_valid_q || !out_stall;
	assign mul_p      = mul_a * mul_b;

	assign ram_base  = RAW'(idx_q) * RAW'(MAX_GAPS_PER_POCKET);
	assign ram_waddr = ram_base + RAW'(gt);
	assign ram_raddr = ram_base + RAW'(gh);

	assign cfg_ready    = 1'b1;
	assign out_valid    = out_valid_q;
	assign unit_address = out_addr_q;
	assign pocket_used  = out_pocket_q;
	assign status       = out_stat_q;

	fupa_ram #(
		.WIDTH(AW),
		.DEPTH(RD)
	) u_gap_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (addr_q),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			fupa_pkg::S_IDLE: begin
				if (accept) begin
					state_d = (operation == fupa_pkg::OP_FREE) ? fupa_pkg::S_FMUL
						: fupa_pkg::S_ACHK;
				end
			end
			fupa_pkg::S_ACHK: begin
				state_d = (fb_short && cur_last) ? fupa_pkg::S_EMIT : fupa_pkg::S_ASCAN;
			end
			fupa_pkg::S_ASCAN: begin
				if (gc != '0) begin
					state_d = fupa_pkg::S_AREAD;
				end else if (idx_is_cur) begin
					state_d = fupa_pkg::S_ABUMP;
				end
			end
			fupa_pkg::S_AREAD:  state_d = fupa_pkg::S_EMIT;
			fupa_pkg::S_ABUMP:  state_d = fb_short ? fupa_pkg::S_EMIT : fupa_pkg::S_AMUL;
			fupa_pkg::S_AMUL:   state_d = fupa_pkg::S_AADD;
			fupa_pkg::S_AADD:   state_d = fupa_pkg::S_EMIT;
			fupa_pkg::S_FMUL:   state_d = fupa_pkg::S_FSTART;
			fupa_pkg::S_FSTART: state_d = fupa_pkg::S_FSCAN;
			fupa_pkg::S_FSCAN: begin
				if (in_range || idx_zero) begin
					state_d = fupa_pkg::S_EMIT;
				end
			end
			fupa_pkg::S_EMIT: begin
				if (can_emit) begin
					state_d = fupa_pkg::S_IDLE;
				end
			end
			default: state_d = fupa_pkg::S_IDLE;
		endcase
	end

	// Sequencer outputs: handshake, memory strobes and multiplier operands.
	always_comb begin
		in_stall = (state_q != fupa_pkg::S_IDLE);
		ram_we   = 1'b0;
		ram_re   = 1'b0;
		mul_a    = '0;
		mul_b    = '0;
		unique case (state_q)
			fupa_pkg::S_ASCAN: ram_re = (gc != '0);
			fupa_pkg::S_ABUMP: begin
				mul_a = bump_q;
				mul_b = PBW'(unit_bytes_q);
			end
			fupa_pkg::S_AMUL, fupa_pkg::S_FMUL: begin
				mul_a = PBW'(cur_q);
				mul_b = pocket_bytes_q;
			end
			fupa_pkg::S_FSCAN: ram_we = in_range && !gap_full;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= fupa_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			unit_bytes_q   <= fupa_pkg::UNIT_BYTES_RST;
			pocket_bytes_q <= fupa_pkg::POCKET_BYTES_RST;
			pool_base_q    <= fupa_pkg::POOL_BASE_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (fupa_pkg::cfg_idx_t'(cfg_index))
				fupa_pkg::CFG_UNIT_BYTES:   unit_bytes_q   <= cfg_data[UW-1:0];
				fupa_pkg::CFG_POCKET_BYTES: pocket_bytes_q <= cfg_data[PBW-1:0];
				fupa_pkg::CFG_POOL_BASE:    pool_base_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	// Per-pocket bookkeeping. It is touched at the scan index, but for the free count of a newly opened pocket.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q  <= '0;
			bump_q <= '0;
			for (int i = 0; i < MAX_POCKETS; i++) begin
				free_q[i]  <= (i == 0) ? fupa_pkg::POCKET_BYTES_RST : '0;
				gcnt_q[i]  <= '0;
				ghead_q[i] <= '0;
				gtail_q[i] <= '0;
			end
		end else begin
			unique case (state_q)
				fupa_pkg::S_ACHK: begin
					// The current pocket cannot hold another unit: open the next one.
					if (fb_short && !cur_last) begin
						cur_q  <= cur_q + 1'b1;
						bump_q <= '0;
						free_q[cur_q + 1'b1] <= pocket_bytes_q;
					end
				end
				fupa_pkg::S_ASCAN: begin
					if (gc != '0) begin
						ghead_q[idx_q] <= (gh == GW'(MAX_GAPS_PER_POCKET - 1)) ? '0 : gh + 1'b1;
						gcnt_q[idx_q]  <= gc - 1'b1;
						free_q[idx_q]  <= debit_val;
					end
				end
				fupa_pkg::S_AADD: begin
					free_q[idx_q] <= debit_val;
					bump_q        <= bump_q + 1'b1;
				end
				fupa_pkg::S_FSCAN: begin
					if (in_range && !gap_full) begin
						gtail_q[idx_q] <= (gt == GW'(MAX_GAPS_PER_POCKET - 1)) ? '0 : gt + 1'b1;
						gcnt_q[idx_q]  <= gc + 1'b1;
						free_q[idx_q]  <= credit_val;
					end
				end
				default: ;
			endcase
		end
	end

	// Datapath registers of the item in flight.
	always_ff @(posedge clk) begin
		unique case (state_q)
			fupa_pkg::S_IDLE: begin
				if (accept) begin
					op_q   <= operation;
					addr_q <= free_address;
					idx_q  <= cur_q;
				end
			end
			fupa_pkg::S_ACHK: begin
				res_addr_q   <= '0;
				res_pocket_q <= cur_q;
				res_stat_q   <= fupa_pkg::STAT_NO_POCKET;
				idx_q        <= '0;
			end
			fupa_pkg::S_ASCAN: begin
				res_pocket_q <= idx_q;
				res_stat_q   <= fupa_pkg::STAT_OK;
				if (gc == '0 && !idx_is_cur) begin
					idx_q <= idx_q + 1'b1;
				end
			end
			fupa_pkg::S_AREAD: res_addr_q <= ram_rdata;
			fupa_pkg::S_ABUMP: begin
				prod_q       <= mul_p[AW-1:0];
				res_addr_q   <= '0;
				res_pocket_q <= cur_q;
				res_stat_q   <= fb_short ? fupa_pkg::STAT_NO_POCKET : fupa_pkg::STAT_OK;
			end
			fupa_pkg::S_AMUL: begin
				acc_q  <= prod_q + pool_base_q;
				prod_q <= mul_p[AW-1:0];
			end
			fupa_pkg::S_AADD: res_addr_q <= acc_q + prod_q;
			fupa_pkg::S_FMUL: prod_q <= mul_p[AW-1:0];
			fupa_pkg::S_FSTART: acc_q <= pool_base_q + prod_q;
			fupa_pkg::S_FSCAN: begin
				// Walk from the newest pocket down, stepping the start back.
				res_addr_q <= '0;
				if (in_range) begin
					res_pocket_q <= idx_q;
					res_stat_q   <= gap_full ? fupa_pkg::STAT_GAP_FULL : fupa_pkg::STAT_OK;
				end else begin
					res_pocket_q <= '0;
					res_stat_q   <= fupa_pkg::STAT_OUTSIDE;
					idx_q        <= idx_q - 1'b1;
					acc_q        <= acc_q - {{(AW - PBW){1'b0}}, pocket_bytes_q};
				end
			end
			default: ;
		endcase
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == fupa_pkg::S_EMIT && can_emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == fupa_pkg::S_EMIT && can_emit) begin
			out_addr_q   <= res_addr_q;
			out_pocket_q <= fupa_pkg::POCKET_IDX_W'(res_pocket_q);
			out_stat_q   <= res_stat_q;
		end
	end

`ifndef SYNTHESIS
	a_cur_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cur_q <= PW'(MAX_POCKETS - 1))
		else $error("current pocket beyond the pocket count");

	a_gap_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != fupa_pkg::S_IDLE) |-> (gc <= CW'(MAX_GAPS_PER_POCKET)))
		else $error("gap count beyond the queue depth");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> in_stall)
		else $error("new item taken while one is in flight");

	a_err_zero_addr: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status != fupa_pkg::STAT_OK) |-> (unit_address == '0))
		else $error("error result carries an address");

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		ram_re |-> (gc != '0 && op_q == fupa_pkg::OP_ALLOC))
		else $error("gap read from an empty queue");
`endif

endmodule

`default_nettype wire

### sv/fupa_ram.sv
`default_nettype none

module fupa_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 4096
) (
	input  wire logic                                  clk,
	input  wire logic                                  we,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                      wdata,
	input  wire logic                                  re,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                      rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire
